/* rtl/mdm_pkg.sv */
// Package with types, codes and frame helpers of the MDIO bus master.
package mdm_pkg;

  localparam int PREAMBLE_BITS = 32;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] PRE_LAST = CNT_W'(PREAMBLE_BITS);
  localparam logic [CNT_W-1:0] HDR_LEN_WR = 6'd16;
  localparam logic [CNT_W-1:0] HDR_LEN_RD = 6'd15;
  localparam logic [CNT_W-1:0] DATA_BITS = 6'd16;
  localparam logic [CNT_W-1:0] FLUSH_BITS = 6'd32;
  localparam logic [15:0] TA_ERR_WORD = 16'hFFFF;

  localparam logic [2:0] FUNC_C22W = 3'd0;
  localparam logic [2:0] FUNC_C22R = 3'd1;
  localparam logic [2:0] FUNC_C45W = 3'd2;
  localparam logic [2:0] FUNC_C45R = 3'd3;
  localparam logic [2:0] FUNC_RMW = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_HDR   = 3'd2,
    PH_DATA  = 3'd3,
    PH_RTA   = 3'd4,
    PH_RDATA = 3'd5,
    PH_FLUSH = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    FR_C22W = 3'd0,
    FR_C22R = 3'd1,
    FR_C45A = 3'd2,
    FR_C45W = 3'd3,
    FR_C45R = 3'd4
  } frame_e;

  typedef struct packed {
    logic        cmd_valid;
    logic [2:0]  func;
    logic [4:0]  port_addr;
    logic [4:0]  device;
    logic [15:0] reg_addr;
    logic [15:0] write_data;
    logic [15:0] mask;
    logic        mdio_in;
  } in_item_t;

  typedef struct packed {
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        ta_error;
  } res_item_t;

  function automatic frame_e frame_kind(logic [2:0] func, logic [1:0] fidx);
    frame_e k;
    unique case (func)
      FUNC_C22W: k = FR_C22W;
      FUNC_C22R: k = FR_C22R;
      FUNC_C45W: k = (fidx == 2'd0) ? FR_C45A : FR_C45W;
      FUNC_C45R: k = (fidx == 2'd0) ? FR_C45A : FR_C45R;
      default: begin
        unique case (fidx)
          2'd0: k = FR_C45A;
          2'd1: k = FR_C45R;
          2'd2: k = FR_C45A;
          default: k = FR_C45W;
        endcase
      end
    endcase
    return k;
  endfunction

  function automatic logic [1:0] last_frame(logic [2:0] func);
    logic [1:0] l;
    if (func <= FUNC_C22R) begin
      l = 2'd0;
    end else if (func <= FUNC_C45R) begin
      l = 2'd1;
    end else begin
      l = 2'd3;
    end
    return l;
  endfunction

  function automatic logic [15:0] header_word(frame_e kind, logic [4:0] phy,
                                              logic [4:0] dev, logic [15:0] regad);
    logic [1:0] st;
    logic [1:0] op;
    logic [4:0] low5;
    st = 2'd0;
    unique case (kind)
      FR_C22W: begin st = 2'd1; op = 2'd1; end
      FR_C22R: begin st = 2'd1; op = 2'd2; end
      FR_C45A: op = 2'd0;
      FR_C45W: op = 2'd1;
      default: op = 2'd3;
    endcase
    low5 = (kind == FR_C22W || kind == FR_C22R) ? regad[4:0] : dev;
    return {st, op, phy, low5, 2'b10};
  endfunction

  function automatic logic [15:0] written_word(frame_e kind, logic [2:0] func,
                                               logic [15:0] regad, logic [15:0] shift,
                                               logic [15:0] mask, logic [15:0] wdata);
    logic [15:0] w;
    if (kind == FR_C45A) begin
      w = regad;
    end else if (func == FUNC_RMW) begin
      w = (shift & mask) | wdata;
    end else begin
      w = wdata;
    end
    return w;
  endfunction

endpackage

/* rtl/mdm_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface mdm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd_valid;
  logic [2:0]  func;
  logic [4:0]  port_addr;
  logic [4:0]  device;
  logic [15:0] reg_addr;
  logic [15:0] write_data;
  logic [15:0] mask;
  logic        mdio_in;

  modport source (
    output valid, cmd_valid, func, port_addr, device, reg_addr, write_data, mask, mdio_in,
    input  ready
  );
  modport sink (
    input  valid, cmd_valid, func, port_addr, device, reg_addr, write_data, mask, mdio_in,
    output ready
  );
endinterface

interface mdm_out_if;
  logic        valid;
  logic        ready;
  logic        mdio_out;
  logic        mdio_drive;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;
  logic        ta_error;

  modport source (
    output valid, mdio_out, mdio_drive, busy_res, done_res, read_data, ta_error,
    input  ready
  );
  modport sink (
    input  valid, mdio_out, mdio_drive, busy_res, done_res, read_data, ta_error,
    output ready
  );
endinterface

/* rtl/mdm_core.sv */
// Frame sequencer state and single-period bit logic of the MDIO bus master.
module mdm_core
  import mdm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output res_item_t res_o
);

  phase_e           phase_q, phase_d;
  logic [1:0]       fidx_q, fidx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      shift_q, shift_d;
  logic             err_q, err_d;
  logic [2:0]       func_q, func_d;
  logic [4:0]       phy_q, phy_d;
  logic [4:0]       dev_q, dev_d;
  logic [15:0]      reg_q, reg_d;
  logic [15:0]      mask_q, mask_d;
  logic [15:0]      wdata_q, wdata_d;

  logic             start;
  phase_e           ph;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] hdr_len;
  logic [15:0]      hdr;
  logic [15:0]      wword;
  frame_e           kind;
  logic             frame_end;

  always_comb begin
    start = (phase_q == PH_IDLE) && item_i.cmd_valid && (item_i.func <= FUNC_RMW);

    ph      = start ? PH_PRE : phase_q;
    cnt     = start ? '0 : cnt_q;
    fidx_d  = start ? 2'd0 : fidx_q;
    shift_d = start ? 16'd0 : shift_q;
    err_d   = start ? 1'b0 : err_q;
    func_d  = start ? item_i.func : func_q;
    phy_d   = start ? item_i.port_addr : phy_q;
    dev_d   = start ? item_i.device : dev_q;
    reg_d   = start ? item_i.reg_addr : reg_q;
    mask_d  = start ? item_i.mask : mask_q;
    wdata_d = start ? item_i.write_data : wdata_q;

    phase_d   = ph;
    cnt_d     = cnt;
    cnt_inc   = cnt + 1'b1;
    kind      = frame_kind(func_d, fidx_d);
    hdr_len   = (kind == FR_C22R || kind == FR_C45R) ? HDR_LEN_RD : HDR_LEN_WR;
    hdr       = header_word(kind, phy_d, dev_d, reg_d);
    wword     = written_word(kind, func_d, reg_d, shift_q, mask_d, wdata_d);
    frame_end = 1'b0;
    res_o     = '0;
    res_o.busy_res = 1'b1;

    unique case (ph)
      PH_IDLE: begin
        res_o.busy_res = 1'b0;
      end
      PH_PRE: begin
        res_o.mdio_drive = 1'b1;
        res_o.mdio_out   = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_inc >= PRE_LAST) begin
          cnt_d   = '0;
          phase_d = PH_HDR;
        end
      end
      PH_HDR: begin
        res_o.mdio_drive = 1'b1;
        res_o.mdio_out   = hdr[~cnt[3:0]];
        cnt_d = cnt_inc;
        if (cnt_inc >= hdr_len) begin
          cnt_d   = '0;
          phase_d = (hdr_len == HDR_LEN_RD) ? PH_RTA : PH_DATA;
        end
      end
      PH_DATA: begin
        res_o.mdio_drive = 1'b1;
        res_o.mdio_out   = wword[~cnt[3:0]];
        cnt_d     = cnt_inc;
        frame_end = (cnt_inc >= DATA_BITS);
      end
      PH_RTA: begin
        cnt_d = '0;
        if (item_i.mdio_in) begin
          err_d   = 1'b1;
          shift_d = TA_ERR_WORD;
          phase_d = PH_FLUSH;
        end else begin
          shift_d = 16'd0;
          phase_d = PH_RDATA;
        end
      end
      PH_RDATA: begin
        shift_d   = {shift_d[14:0], item_i.mdio_in};
        cnt_d     = cnt_inc;
        frame_end = (cnt_inc >= DATA_BITS);
      end
      PH_FLUSH: begin
        cnt_d     = cnt_inc;
        frame_end = (cnt_inc >= FLUSH_BITS);
      end
      default: begin
        res_o.busy_res = 1'b0;
        phase_d = PH_IDLE;
        cnt_d   = '0;
        fidx_d  = 2'd0;
        shift_d = 16'd0;
        err_d   = 1'b0;
      end
    endcase

    if (frame_end) begin
      if (fidx_d >= last_frame(func_d)) begin
        res_o.done_res = 1'b1;
        unique case (func_d)
          FUNC_C22R: begin
            res_o.read_data = shift_d;
            res_o.ta_error  = err_d;
          end
          FUNC_C45R: begin
            res_o.read_data = shift_d & mask_d;
            res_o.ta_error  = err_d;
          end
          FUNC_RMW: begin
            res_o.read_data = written_word(FR_C45W, func_d, reg_d, shift_d, mask_d,
                                           wdata_d);
            res_o.ta_error  = err_d;
          end
          default: begin
            res_o.read_data = 16'd0;
            res_o.ta_error  = 1'b0;
          end
        endcase
        phase_d = PH_IDLE;
        fidx_d  = 2'd0;
        cnt_d   = '0;
        shift_d = 16'd0;
        err_d   = 1'b0;
      end else begin
        fidx_d  = fidx_d + 2'd1;
        cnt_d   = '0;
        phase_d = PH_PRE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fidx_q  <= 2'd0;
      cnt_q   <= '0;
      shift_q <= 16'd0;
      err_q   <= 1'b0;
      func_q  <= 3'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      fidx_q  <= fidx_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      err_q   <= err_d;
      func_q  <= func_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      phy_q   <= phy_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      mask_q  <= mask_d;
      wdata_q <= wdata_d;
    end
  end

endmodule

/* rtl/mdio_bus_master_top.sv */
// Top level of the MDIO bus master: channel handshakes and result register.
//
//   channel  direction  carries
//   in_i     sink       one MDC bit period: sampled data line and optional command
//   out_o    source     line drive, busy, done, read data and turnaround error
//
// One item is accepted per cycle unless the output stalls; its result appears in
// the output register the cycle after acceptance. The sequencer state and the
// result register each hold one item, giving one item per clock when not stalled.
// Reset returns the sequencer to idle and empties the result register.
// A stalled result holds its value; a new item is taken whenever the result
// register is empty or is being drained in the same cycle.
module mdio_bus_master_top
  import mdm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mdm_in_if.sink    in_i,
  mdm_out_if.source out_o
);

  in_item_t  item;
  res_item_t res;
  res_item_t res_q;
  logic      out_valid_q;
  logic      accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign item.cmd_valid  = in_i.cmd_valid;
  assign item.func       = in_i.func;
  assign item.port_addr  = in_i.port_addr;
  assign item.device     = in_i.device;
  assign item.reg_addr   = in_i.reg_addr;
  assign item.write_data = in_i.write_data;
  assign item.mask       = in_i.mask;
  assign item.mdio_in    = in_i.mdio_in;

  mdm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .item_i (item),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.mdio_out   = res_q.mdio_out;
  assign out_o.mdio_drive = res_q.mdio_drive;
  assign out_o.busy_res   = res_q.busy_res;
  assign out_o.done_res   = res_q.done_res;
  assign out_o.read_data  = res_q.read_data;
  assign out_o.ta_error   = res_q.ta_error;

endmodule
